// File: hw/rtl/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants for the edge-biconnected component unit.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int unsigned NodeW = 6;
  localparam int unsigned CntW  = 7;
  localparam logic [CntW-1:0] NodeCountRst = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SCANW,
    ST_VTW,
    ST_CLOSE,
    ST_POPR,
    ST_POPW,
    ST_RET,
    ST_RETW,
    ST_OUTR,
    ST_OUTV
  } state_e;

endpackage

// File: hw/rtl/ebc_ram.sv
// ----------------------------------------------------------------------------
// ebc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ebc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/edge_biconnected_components_unit.sv
// ----------------------------------------------------------------------------
// edge_biconnected_components_unit
// Loads undirected edges, then runs a low-link depth-first walk from node 0
// and streams one component word per node.
// ----------------------------------------------------------------------------
// Load: one edge word per cycle, no results unless tlast.
// Walk: a start state; each entered node scans all 2*E edge slots in
//   SCAN/SCANW, plus a VTW lookup per visited, unassigned neighbor; close
//   check, node-stack pops (POPR, POPW), returns (RET, RETW; root: RET).
//   Input not ready. Output per node word: component RAM read, then hold.
// Reset: async active low; clears edge count, drop flag, node_count to 64.
module edge_biconnected_components_unit
  import ebc_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // edge_u[5:0], edge_v[11:6], zero pad
  input  logic        s_axis_tuser_i,   // has_edge
  input  logic        s_axis_tlast_i,   // last_edge
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // node_index[5:0], component[11:6], zero pad
  output logic [1:0]  m_axis_tuser_o,   // reached, overflow
  output logic        m_axis_tlast_o    // last_node
);

  localparam int unsigned NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW  = ECW + 1;
  localparam int unsigned DW  = $clog2(MAX_NODES + 1);
  localparam int unsigned FW  = 2 * NodeW + 1 + PW + 2 * DW;
  localparam int unsigned EW  = 2 * NodeW;

  state_e state_q, state_d;
  logic [CntW-1:0] cfg_n_q;
  logic [CntW-1:0] n_q, n_d;
  logic [ECW-1:0]  total_q, total_d;
  logic            drop_q, drop_d;
  logic [MAX_NODES-1:0] visited_q, visited_d, assigned_q, assigned_d;
  logic [DW-1:0]   ndepth_q, ndepth_d, fdepth_q, fdepth_d;
  logic [DW-1:0]   time_q, time_d, ccount_q, ccount_d;
  logic [NodeW-1:0] cur_node_q, cur_node_d, cur_par_q, cur_par_d;
  logic            cur_hasp_q, cur_hasp_d;
  logic [PW-1:0]   cur_pos_q, cur_pos_d;
  logic [DW-1:0]   cur_vt_q, cur_vt_d, cur_low_q, cur_low_d;
  logic [CntW-1:0] idx_q, idx_d;

  // RAM ports
  logic            e_we;
  logic [EAW-1:0]  e_waddr, e_raddr;
  logic [EW-1:0]   e_wdata, e_rdata;
  logic            vt_we;
  logic [NAW-1:0]  vt_waddr, vt_raddr;
  logic [DW-1:0]   vt_wdata, vt_rdata;
  logic            ns_we;
  logic [NAW-1:0]  ns_waddr, ns_raddr;
  logic [NodeW-1:0] ns_wdata, ns_rdata;
  logic            cm_we;
  logic [NAW-1:0]  cm_waddr, cm_raddr;
  logic [NodeW-1:0] cm_wdata, cm_rdata;
  logic            fr_we;
  logic [NAW-1:0]  fr_waddr, fr_raddr;
  logic [FW-1:0]   fr_wdata, fr_rdata;

  ebc_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  ebc_ram #(.Width(DW), .Depth(MAX_NODES)) u_vt_ram (
    .clk_i, .we_i(vt_we), .waddr_i(vt_waddr), .wdata_i(vt_wdata),
    .raddr_i(vt_raddr), .rdata_o(vt_rdata)
  );
  ebc_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_stack_ram (
    .clk_i, .we_i(ns_we), .waddr_i(ns_waddr), .wdata_i(ns_wdata),
    .raddr_i(ns_raddr), .rdata_o(ns_rdata)
  );
  ebc_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_comp_ram (
    .clk_i, .we_i(cm_we), .waddr_i(cm_waddr), .wdata_i(cm_wdata),
    .raddr_i(cm_raddr), .rdata_o(cm_rdata)
  );
  ebc_ram #(.Width(FW), .Depth(MAX_NODES)) u_frame_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  logic             in_acc;
  logic [NodeW-1:0] ea, eb, ey, fr_node, fr_par;
  logic             in_rng, found, fr_hasp;
  logic [PW-1:0]    fr_pos;
  logic [DW-1:0]    fr_vt, fr_low;
  logic [CntW-1:0]  eff_n;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign ea = e_rdata[NodeW-1:0];
  assign eb = e_rdata[EW-1:NodeW];
  assign in_rng = ({1'b0, ea} < n_q) && ({1'b0, eb} < n_q);
  assign found = in_rng && (cur_pos_q[0] ? (eb == cur_node_q) : (ea == cur_node_q));
  assign ey = cur_pos_q[0] ? ea : eb;
  assign {fr_node, fr_par, fr_hasp, fr_pos, fr_vt, fr_low} = fr_rdata;

  always_comb begin
    if (cfg_n_q == '0) begin
      eff_n = CntW'(1);
    end else if (cfg_n_q > CntW'(MAX_NODES)) begin
      eff_n = CntW'(MAX_NODES);
    end else begin
      eff_n = cfg_n_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q <= NodeCountRst;
    end else if (cfg_we_i) begin
      cfg_n_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      n_q        <= '0;
      total_q    <= '0;
      drop_q     <= 1'b0;
      visited_q  <= '0;
      assigned_q <= '0;
      ndepth_q   <= '0;
      fdepth_q   <= '0;
      time_q     <= '0;
      ccount_q   <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      total_q    <= total_d;
      drop_q     <= drop_d;
      visited_q  <= visited_d;
      assigned_q <= assigned_d;
      ndepth_q   <= ndepth_d;
      fdepth_q   <= fdepth_d;
      time_q     <= time_d;
      ccount_q   <= ccount_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_node_q <= cur_node_d;
    cur_par_q  <= cur_par_d;
    cur_hasp_q <= cur_hasp_d;
    cur_pos_q  <= cur_pos_d;
    cur_vt_q   <= cur_vt_d;
    cur_low_q  <= cur_low_d;
  end

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    total_d    = total_q;
    drop_d     = drop_q;
    visited_d  = visited_q;
    assigned_d = assigned_q;
    ndepth_d   = ndepth_q;
    fdepth_d   = fdepth_q;
    time_d     = time_q;
    ccount_d   = ccount_q;
    idx_d      = idx_q;
    cur_node_d = cur_node_q;
    cur_par_d  = cur_par_q;
    cur_hasp_d = cur_hasp_q;
    cur_pos_d  = cur_pos_q;
    cur_vt_d   = cur_vt_q;
    cur_low_d  = cur_low_q;

    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    e_we     = 1'b0;
    e_waddr  = total_q[EAW-1:0];
    e_wdata  = s_axis_tdata_i[EW-1:0];
    e_raddr  = cur_pos_q[EAW:1];
    vt_we    = 1'b0;
    vt_waddr = ey[NAW-1:0];
    vt_wdata = time_q;
    vt_raddr = ey[NAW-1:0];
    ns_we    = 1'b0;
    ns_waddr = ndepth_q[NAW-1:0];
    ns_wdata = ey;
    ns_raddr = NAW'(ndepth_q - DW'(1));
    cm_we    = 1'b0;
    cm_waddr = ns_rdata[NAW-1:0];
    cm_wdata = ccount_q[NodeW-1:0];
    cm_raddr = idx_q[NAW-1:0];
    fr_we    = 1'b0;
    fr_waddr = NAW'(fdepth_q - DW'(1));
    fr_wdata = {cur_node_q, cur_par_q, cur_hasp_q, PW'(cur_pos_q + PW'(1)),
                cur_vt_q, cur_low_q};
    fr_raddr = NAW'(fdepth_q - DW'(2));

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            if (total_q < ECW'(MAX_EDGES)) begin
              e_we    = 1'b1;
              total_d = ECW'(total_q + ECW'(1));
            end else begin
              drop_d = 1'b1;
            end
          end
          if (s_axis_tlast_i) begin
            n_d     = eff_n;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        visited_d  = '0;
        visited_d[0] = 1'b1;
        assigned_d = '0;
        vt_we      = 1'b1;
        vt_waddr   = '0;
        vt_wdata   = '0;
        ns_we      = 1'b1;
        ns_waddr   = '0;
        ns_wdata   = '0;
        ndepth_d   = DW'(1);
        fdepth_d   = DW'(1);
        time_d     = DW'(1);
        ccount_d   = '0;
        cur_node_d = '0;
        cur_par_d  = '0;
        cur_hasp_d = 1'b0;
        cur_pos_d  = '0;
        cur_vt_d   = '0;
        cur_low_d  = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (cur_pos_q >= {total_q, 1'b0}) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_SCANW;
        end
      end
      ST_SCANW: begin
        cur_pos_d = PW'(cur_pos_q + PW'(1));
        state_d   = ST_SCAN;
        if (found && !(cur_hasp_q && (ey == cur_par_q))) begin
          if (!visited_q[ey[NAW-1:0]]) begin
            visited_d[ey[NAW-1:0]] = 1'b1;
            vt_we      = 1'b1;
            ns_we      = 1'b1;
            fr_we      = 1'b1;
            ndepth_d   = DW'(ndepth_q + DW'(1));
            fdepth_d   = DW'(fdepth_q + DW'(1));
            time_d     = DW'(time_q + DW'(1));
            cur_node_d = ey;
            cur_par_d  = cur_node_q;
            cur_hasp_d = 1'b1;
            cur_pos_d  = '0;
            cur_vt_d   = time_q;
            cur_low_d  = time_q;
          end else if (!assigned_q[ey[NAW-1:0]]) begin
            state_d = ST_VTW;
          end
        end
      end
      ST_VTW: begin
        if ((vt_rdata < cur_vt_q) && (vt_rdata < cur_low_q)) begin
          cur_low_d = vt_rdata;
        end
        state_d = ST_SCAN;
      end
      ST_CLOSE: begin
        state_d = (cur_vt_q == cur_low_q) ? ST_POPR : ST_RET;
      end
      ST_POPR: begin
        ndepth_d = DW'(ndepth_q - DW'(1));
        state_d  = ST_POPW;
      end
      ST_POPW: begin
        assigned_d[ns_rdata[NAW-1:0]] = 1'b1;
        cm_we = 1'b1;
        if (ns_rdata == cur_node_q) begin
          ccount_d = DW'(ccount_q + DW'(1));
          state_d  = ST_RET;
        end else begin
          state_d = ST_POPR;
        end
      end
      ST_RET: begin
        fdepth_d = DW'(fdepth_q - DW'(1));
        if (fdepth_q == DW'(1)) begin
          idx_d   = '0;
          state_d = ST_OUTR;
        end else begin
          state_d = ST_RETW;
        end
      end
      ST_RETW: begin
        cur_node_d = fr_node;
        cur_par_d  = fr_par;
        cur_hasp_d = fr_hasp;
        cur_pos_d  = fr_pos;
        cur_vt_d   = fr_vt;
        cur_low_d  = (cur_low_q < fr_low) ? cur_low_q : fr_low;
        state_d    = ST_SCAN;
      end
      ST_OUTR: begin
        state_d = ST_OUTV;
      end
      ST_OUTV: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (idx_q == CntW'(n_q - CntW'(1))) begin
            total_d = '0;
            drop_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = CntW'(idx_q + CntW'(1));
            state_d = ST_OUTR;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  logic reach_o;
  assign reach_o = visited_q[idx_q[NAW-1:0]];
  assign m_axis_tdata_o = {4'b0, (reach_o ? cm_rdata : NodeW'(0)), idx_q[NodeW-1:0]};
  assign m_axis_tuser_o = {drop_q, reach_o};
  assign m_axis_tlast_o = (idx_q == CntW'(n_q - CntW'(1)));

  a_fdepth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdepth_q <= DW'(MAX_NODES)) else $error("frame stack overrun");
  a_ndepth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndepth_q <= DW'(MAX_NODES)) else $error("node stack overrun");
  a_scan_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (fdepth_q != '0)) else $error("scan without frame");
  a_comp_le_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_START) |-> (ccount_q <= time_q))
    else $error("more components than visited nodes");

endmodule

// File: tb/ebc_checker.sv
// ----------------------------------------------------------------------------
// ebc_checker
// Watches the edge and component streams of the unit, recomputes the
// edge-biconnected decomposition for every graph and checks each node word.
// ----------------------------------------------------------------------------
module ebc_checker
  import ebc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [5:0] node;
    logic [5:0] comp;
    logic       reached;
    logic       overflow;
    logic       last;
  } node_word_t;

  localparam int MaxEdges = 256;

  logic [5:0]    edge_u_q [MaxEdges];
  logic [5:0]    edge_v_q [MaxEdges];
  int            edge_cnt;
  bit            dropped;
  logic [6:0]    node_count;
  node_word_t    component_words [$];

  assign pending_o = component_words.size();

  function automatic void decompose(int n);
    bit seen [64];
    bit done [64];
    int vt [64];
    int lt [64];
    int comp [64];
    int stk [64];
    int fnode [64];
    int fpar [64];
    bit fhp [64];
    int fpos [64];
    int sdep, fd, tick, cc, top, x, y, e, a, b, w, par;
    bit found;
    node_word_t r;
    for (int i = 0; i < 64; i++) begin
      seen[i] = 0;
      done[i] = 0;
    end
    seen[0] = 1; vt[0] = 0; lt[0] = 0; tick = 1; cc = 0;
    stk[0] = 0; sdep = 1;
    fnode[0] = 0; fpar[0] = 0; fhp[0] = 0; fpos[0] = 0; fd = 1;
    while (fd > 0) begin
      top = fd - 1;
      x = fnode[top];
      found = 0;
      y = 0;
      while (!found && fpos[top] < 2 * edge_cnt) begin
        e = fpos[top] >> 1;
        a = edge_u_q[e];
        b = edge_v_q[e];
        if (a < n && b < n) begin
          if (!fpos[top][0] && a == x) begin y = b; found = 1; end
          else if (fpos[top][0] && b == x) begin y = a; found = 1; end
        end
        fpos[top]++;
      end
      if (found) begin
        if (fhp[top] && y == fpar[top]) continue;
        if (!seen[y]) begin
          seen[y] = 1; vt[y] = tick; lt[y] = tick; tick++;
          stk[sdep] = y; sdep++;
          fnode[fd] = y; fpar[fd] = x; fhp[fd] = 1; fpos[fd] = 0; fd++;
        end else if (!done[y] && vt[y] < vt[x] && vt[y] < lt[x]) begin
          lt[x] = vt[y];
        end
        continue;
      end
      if (vt[x] == lt[x]) begin
        while (sdep > 0) begin
          sdep--;
          w = stk[sdep];
          done[w] = 1;
          comp[w] = cc;
          if (w == x) break;
        end
        cc++;
      end
      fd--;
      if (fd > 0) begin
        par = fnode[fd-1];
        if (lt[x] < lt[par]) lt[par] = lt[x];
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node     = i[5:0];
      r.reached  = seen[i] && done[i];
      r.comp     = r.reached ? comp[i][5:0] : 6'd0;
      r.overflow = dropped;
      r.last     = (i == n - 1);
      component_words.insert(component_words.size(), r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    node_word_t got, exp_w;
    int n;
    if (!rst_ni) begin
      edge_cnt   = 0;
      dropped    = 0;
      node_count <= NodeCountRst;
      errors_o   <= 0;
    end else begin
      if (cfg_we_i) node_count <= cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i) begin
          if (edge_cnt < MaxEdges) begin
            edge_u_q[edge_cnt] = s_axis_tdata_i[5:0];
            edge_v_q[edge_cnt] = s_axis_tdata_i[11:6];
            edge_cnt = edge_cnt + 1;
          end else begin
            dropped = 1;
          end
        end
        if (s_axis_tlast_i) begin
          n = (node_count == 0) ? 1 : (node_count > 64) ? 64 : node_count;
          decompose(n);
          edge_cnt = 0;
          dropped  = 0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[5:0], m_axis_tdata_i[11:6], m_axis_tuser_i[0],
               m_axis_tuser_i[1], m_axis_tlast_i};
        if (component_words.size() == 0) begin
          $display("%0t: unexpected word node=%0d comp=%0d", $time, got.node, got.comp);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = component_words.pop_front();
          if (got.node != exp_w.node || got.comp != exp_w.comp ||
              got.reached != exp_w.reached || got.overflow != exp_w.overflow ||
              got.last != exp_w.last) begin
            $display("%0t: mismatch exp node=%0d comp=%0d reach=%0b ovf=%0b last=%0b",
                     $time, exp_w.node, exp_w.comp, exp_w.reached, exp_w.overflow,
                     exp_w.last);
            $display("%0t:          got node=%0d comp=%0d reach=%0b ovf=%0b last=%0b",
                     $time, got.node, got.comp, got.reached, got.overflow, got.last);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives edge graphs into the edge-biconnected component unit under varied
// node counts, idling and back-pressure; a checker verifies every node word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit = 3000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_valid = 0;
  logic        s_ready;
  logic [15:0] s_data = '0;
  logic        s_user = 0;
  logic        s_last = 0;
  logic        m_valid;
  logic        m_ready = 0;
  logic [15:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;
  int          errors;
  int          pending;
  int          s_pct = 0;
  int          m_pct = 0;
  bit          hold_req = 0;
  int          hold_cnt = 0;
  int          cycles = 0;

  edge_biconnected_components_unit i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  ebc_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .errors_o(errors), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt = 3000;
    if (hold_cnt > 0) begin
      m_ready <= 0;
      hold_cnt = hold_cnt - 1;
      if (hold_cnt == 0) hold_req = 0;
    end else begin
      m_ready <= ($urandom_range(99) >= m_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(bit has, logic [5:0] u, logic [5:0] v, bit last);
    if ($urandom_range(99) < s_pct) begin
      s_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1;
    s_data  <= {4'b0, v, u};
    s_user  <= has;
    s_last  <= last;
    do @(negedge clk_i); while (!s_ready);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [6:0] val);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 0;
  endtask

  // random graph over nodes 0..span-1, occasionally stray endpoints
  task automatic send_graph(int edges, int span);
    logic [5:0] u, v;
    bit has;
    for (int i = 0; i < edges; i++) begin
      has = ($urandom_range(9) != 0);
      if ($urandom_range(19) == 0) begin
        u = 6'($urandom); v = 6'($urandom);
      end else begin
        u = 6'($urandom_range(span - 1));
        v = 6'($urandom_range(span - 1));
      end
      send_word(has, u, v, i == edges - 1);
    end
  endtask

  initial begin
    int items, span, n;
    logic [6:0] counts [4];
    counts = '{7'd0, 7'd127, 7'd64, 7'd65};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset node count, lone last word without edge
    send_word(0, 6'd0, 6'd0, 1);
    send_word(1, 6'd0, 6'd63, 0);
    send_word(1, 6'd63, 6'd0, 0);
    send_word(1, 6'd63, 6'd63, 1);
    write_node_count(7'd6);
    // bridge 2-3 between triangle and pair with parallel edges, self loop
    send_word(1, 6'd0, 6'd1, 0);
    send_word(1, 6'd1, 6'd2, 0);
    send_word(1, 6'd2, 6'd0, 0);
    send_word(1, 6'd2, 6'd3, 0);
    send_word(1, 6'd3, 6'd4, 0);
    send_word(1, 6'd4, 6'd3, 0);
    send_word(1, 6'd5, 6'd5, 0);
    send_word(1, 6'd4, 6'd40, 0);
    send_word(0, 6'd63, 6'd63, 1);
    foreach (counts[k]) begin
      write_node_count(counts[k]);
      send_word(1, 6'd0, 6'd1, 0);
      send_word(1, 6'd42, 6'd21, 1);
    end
    // store overflow on a small node set
    write_node_count(7'd4);
    for (int i = 0; i < 260; i++) send_word(1, {4'b0, i[1:0]}, {4'b0, i[3:2]}, i == 259);

    for (int ph = 0; ph < 4; ph++) begin
      s_pct = (ph == 1) ? 56 : (ph == 3) ? 36 : 0;
      m_pct = (ph == 2) ? 56 : (ph == 3) ? 36 : 0;
      items = 0;
      while (items < 10) begin
        if ($urandom_range(7) == 0) begin
          n = ($urandom_range(3) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
          write_node_count(n[6:0]);
        end
        span = (n == 0) ? 8 : n + 1;
        if (span > 64) span = 64;
        n = $urandom_range(1, 14);
        if (ph == 2 && items == 0) hold_req = 1;
        send_graph(n, span);
        items += n;
      end
    end
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
